FILE: rtl/lbcm_pkg.sv
// Shared constants, types and helpers for the linear battery charge model.
package lbcm_pkg;

    // Fixed-point format
    localparam int FRAC_BITS = 16;
    localparam int DATA_W    = 32;
    localparam int PROD_W    = 2 * DATA_W;

    // Product with its fraction bits dropped
    localparam int SHIFT_W   = PROD_W - FRAC_BITS;

    // Dividend of a fixed-point quotient
    localparam int QDIV_W    = DATA_W + FRAC_BITS;

    // Divider width covers both uses, rounded up to an even count (2 bits/cycle)
    localparam int DIV_SPAN  = (QDIV_W > SHIFT_W) ? QDIV_W : SHIFT_W;
    localparam int DIV_W     = ((DIV_SPAN + 1) / 2) * 2;
    localparam int DIV_STEPS = DIV_W / 2;
    localparam int DIV_CNT_W = $clog2(DIV_STEPS + 1);

    // Terminal voltage accumulator: base plus two product terms, signed
    localparam int TOT_W     = SHIFT_W + 3;

    localparam logic [DATA_W-1:0] ONE_Q        = DATA_W'(1) << FRAC_BITS;
    localparam logic [DATA_W-1:0] MV_THRESH    =
        DATA_W'(((64'd1 << FRAC_BITS) + 64'd500) / 64'd1000);
    localparam logic [DATA_W-1:0] SEC_PER_HOUR = DATA_W'(3600);
    localparam logic [DATA_W-1:0] MAX_Q        = '1;

    // Divider status seen by the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } lbcm_div_stat_t;

    // Clamp a divider quotient to 32 bits
    function automatic logic [DATA_W-1:0] sat_quo(input logic [DIV_W-1:0] q);
        return (|q[DIV_W-1:DATA_W]) ? MAX_Q : q[DATA_W-1:0];
    endfunction

endpackage

FILE: rtl/lbcm_div.sv
// Shared restoring divider, two quotient bits per cycle.
module lbcm_div
    import lbcm_pkg::*;
(
    input  logic                 clk,
    input  logic                 rst_n,
    input  logic                 start,
    input  logic [DIV_W-1:0]     dividend,
    input  logic [DATA_W-1:0]    divisor,
    output logic [DIV_W-1:0]     quotient,
    output lbcm_div_stat_t       stat
);

    logic [DIV_W-1:0]     quo_reg;
    logic [DATA_W-1:0]    rem_reg;
    logic [DATA_W-1:0]    dvs_reg;
    logic [DIV_CNT_W-1:0] cnt_reg;
    logic                 done_reg;

    logic [DIV_W-1:0]     quo_next;
    logic [DATA_W-1:0]    rem_next;
    logic [DATA_W:0]      trial;

    // Two restoring steps; dividend bits shift out as quotient bits shift in.
    // A zero divisor yields an all-ones quotient.
    always_comb
    begin
        quo_next = quo_reg;
        rem_next = rem_reg;
        trial    = '0;
        for (int i = 0; i < 2; i++)
        begin
            trial    = {rem_next, quo_next[DIV_W-1]};
            quo_next = {quo_next[DIV_W-2:0], 1'b0};
            if (trial >= {1'b0, dvs_reg})
            begin
                trial       = trial - {1'b0, dvs_reg};
                quo_next[0] = 1'b1;
            end
            rem_next = trial[DATA_W-1:0];
        end
    end

    // Iteration control
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            quo_reg  <= '0;
            rem_reg  <= '0;
            dvs_reg  <= '0;
            cnt_reg  <= '0;
            done_reg <= 1'b0;
        end
        else if (start)
        begin
            quo_reg  <= dividend;
            rem_reg  <= '0;
            dvs_reg  <= divisor;
            cnt_reg  <= DIV_CNT_W'(DIV_STEPS);
            done_reg <= 1'b0;
        end
        else if (cnt_reg != '0)
        begin
            quo_reg  <= quo_next;
            rem_reg  <= rem_next;
            cnt_reg  <= cnt_reg - DIV_CNT_W'(1);
            done_reg <= (cnt_reg == DIV_CNT_W'(1));
        end
        else
        begin
            done_reg <= 1'b0;
        end
    end

    assign quotient  = quo_reg;
    assign stat.busy = (cnt_reg != '0);
    assign stat.done = done_reg;

    // A new division never cuts into one in flight
    ap_start_idle: assert property (@(posedge clk) disable iff (!rst_n)
        start |-> !stat.busy)
        else $error("divider started while busy");

    // Done follows the last step, when the counter has run out
    ap_done_last: assert property (@(posedge clk) disable iff (!rst_n)
        stat.done |-> ($past(cnt_reg) == DIV_CNT_W'(1)) && !stat.busy)
        else $error("divider done without finishing its steps");

endmodule

FILE: rtl/lbcm_mul.sv
// Shared 32x32 multiplier with a registered product.
module lbcm_mul
    import lbcm_pkg::*;
(
    input  logic                 clk,
    input  logic [DATA_W-1:0]    a,
    input  logic [DATA_W-1:0]    b,
    output logic [PROD_W-1:0]    p
);

    logic [PROD_W-1:0] p_reg;

    // Product is registered, ready in the cycle after the operands
    always_ff @(posedge clk)
    begin
        p_reg <= PROD_W'(a) * PROD_W'(b);
    end

    assign p = p_reg;

endmodule

FILE: rtl/linear_battery_charge_model.sv
// Top level: config registers, tick sequencer and result register.
//
// Coulomb-counting battery model. Each input word is a physics tick (bus
// voltage, summed load power, charging flag) or a model reset. A tick forms
// the load current as power over voltage, low-pass filters it with gain
// step_time/time_constant, counts charge down by the filtered current (or up
// by charge_rate while charging) over the step in hours, and returns the
// terminal voltage base + slope*(1 - charge/capacity) - resistance*current,
// all in Q16.16. Under 1 mV the result is all zero with voltage_too_low set
// and the state is kept. One word is worked on at a time: item_stall is high
// from acceptance until the result is placed in the output register, which
// may still be waiting to be taken when the next word is accepted. A normal
// tick makes four passes through the shared divider (current, filter gain,
// charge in hours, charge ratio) at two quotient bits per cycle; the four
// products go through one registered multiplier. Registers sit on an APB port
// at byte address 4*index and may only be written while the block is idle.
module linear_battery_charge_model
    import lbcm_pkg::*;
(
    input  logic                     clk,
    input  logic                     rst_n,

    input  logic                     psel,
    input  logic                     penable,
    input  logic                     pwrite,
    input  logic [4:0]               paddr,
    input  logic [31:0]              pwdata,
    output logic [31:0]              prdata,
    output logic                     pready,

    input  logic                     item_valid,
    output logic                     item_stall,
    input  logic                     action,
    input  logic [DATA_W-1:0]        bus_voltage,
    input  logic [DATA_W-1:0]        load_power,
    input  logic                     charging,

    output logic                     result_valid,
    input  logic                     result_stall,
    output logic signed [DATA_W-1:0] terminal_voltage,
    output logic [DATA_W-1:0]        charge_left,
    output logic [DATA_W-1:0]        load_current,
    output logic [DATA_W-1:0]        smooth_current,
    output logic                     voltage_too_low
);

    typedef enum logic [2:0] {
        REG_OCV_BASE   = 3'd0,
        REG_OCV_SLOPE  = 3'd1,
        REG_RESISTANCE = 3'd2,
        REG_CAPACITY   = 3'd3,
        REG_INIT_CHG   = 3'd4,
        REG_CHG_RATE   = 3'd5,
        REG_STEP_TIME  = 3'd6,
        REG_TIME_CONST = 3'd7
    } cfg_reg_t;

    typedef enum logic [4:0] {
        S_IDLE,
        S_RAW_GO,
        S_RAW_WAIT,
        S_K_GO,
        S_K_WAIT,
        S_FILT_MUL,
        S_FILT_UPD,
        S_AMT_MUL,
        S_AMT_GO,
        S_AMT_WAIT,
        S_RATIO_GO,
        S_RATIO_WAIT,
        S_OCV_MUL,
        S_OCV_ACC,
        S_RES_MUL,
        S_RES_ACC,
        S_OUT
    } state_t;

    localparam logic signed [TOT_W-1:0] TV_MAX = {{(TOT_W-31){1'b0}}, {31{1'b1}}};
    localparam logic signed [TOT_W-1:0] TV_MIN = {{(TOT_W-31){1'b1}}, {31{1'b0}}};
    localparam logic [DATA_W-1:0]       TV_POS = {1'b0, {(DATA_W-1){1'b1}}};
    localparam logic [DATA_W-1:0]       TV_NEG = {1'b1, {(DATA_W-1){1'b0}}};

    // Configuration registers
    logic [DATA_W-1:0] ocv_base_reg;
    logic [DATA_W-1:0] ocv_slope_reg;
    logic [DATA_W-1:0] resistance_reg;
    logic [DATA_W-1:0] capacity_reg;
    logic [DATA_W-1:0] init_charge_reg;
    logic [DATA_W-1:0] charge_rate_reg;
    logic [DATA_W-1:0] step_time_reg;
    logic [DATA_W-1:0] time_const_reg;

    cfg_reg_t          cfg_sel;
    logic              cfg_wr;

    // Sequencer registers
    state_t                   state_reg,   state_next;
    logic                     act_reg,     act_next;
    logic                     low_reg,     low_next;
    logic                     chg_reg,     chg_next;
    logic [DATA_W-1:0]        volt_reg,    volt_next;
    logic [DATA_W-1:0]        power_reg,   power_next;
    logic [DATA_W-1:0]        raw_reg,     raw_next;
    logic [DATA_W-1:0]        k_reg,       k_next;
    logic [DATA_W-1:0]        ratio_reg,   ratio_next;
    logic signed [TOT_W-1:0]  total_reg,   total_next;
    logic [DATA_W-1:0]        filt_reg,    filt_next;
    logic [DATA_W-1:0]        charge_reg,  charge_next;

    // Result register
    logic                     rv_reg,      rv_next;
    logic [DATA_W-1:0]        tv_reg,      tv_next;
    logic [DATA_W-1:0]        cl_reg,      cl_next;
    logic [DATA_W-1:0]        lc_reg,      lc_next;
    logic [DATA_W-1:0]        sc_reg,      sc_next;
    logic                     vtl_reg,     vtl_next;

    // Shared units
    logic                     div_start;
    logic [DIV_W-1:0]         div_dividend;
    logic [DATA_W-1:0]        div_divisor;
    logic [DIV_W-1:0]         div_quo;
    lbcm_div_stat_t           div_stat;
    logic [DATA_W-1:0]        mul_a;
    logic [DATA_W-1:0]        mul_b;
    logic [PROD_W-1:0]        mul_p;

    // Datapath helpers
    logic                     raw_ge;
    logic [DATA_W-1:0]        diff;
    logic [SHIFT_W-1:0]       prod_q;
    logic [SHIFT_W:0]         filt_sum;
    logic [DATA_W-1:0]        filt_upd;
    logic [DIV_W:0]           chg_sum;
    logic [DATA_W-1:0]        charge_upd;
    logic                     ratio_le;
    logic [DATA_W-1:0]        ratio_dev;
    logic signed [TOT_W-1:0]  base_ext;
    logic signed [TOT_W-1:0]  mag_ext;
    logic [DATA_W-1:0]        tv_sat;
    logic                     special;

    lbcm_div u_div (
        .clk      (clk),
        .rst_n    (rst_n),
        .start    (div_start),
        .dividend (div_dividend),
        .divisor  (div_divisor),
        .quotient (div_quo),
        .stat     (div_stat)
    );

    lbcm_mul u_mul (
        .clk (clk),
        .a   (mul_a),
        .b   (mul_b),
        .p   (mul_p)
    );

    // APB register file
    assign pready  = 1'b1;
    assign cfg_sel = cfg_reg_t'(paddr[4:2]);
    assign cfg_wr  = psel && penable && pwrite;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            ocv_base_reg    <= '0;
            ocv_slope_reg   <= '0;
            resistance_reg  <= '0;
            capacity_reg    <= DATA_W'(65536);
            init_charge_reg <= '0;
            charge_rate_reg <= '0;
            step_time_reg   <= DATA_W'(66);
            time_const_reg  <= DATA_W'(65536);
        end
        else if (cfg_wr)
        begin
            case (cfg_sel)
                REG_OCV_BASE:   ocv_base_reg    <= pwdata;
                REG_OCV_SLOPE:  ocv_slope_reg   <= pwdata;
                REG_RESISTANCE: resistance_reg  <= pwdata;
                REG_CAPACITY:   capacity_reg    <= pwdata;
                REG_INIT_CHG:   init_charge_reg <= pwdata;
                REG_CHG_RATE:   charge_rate_reg <= pwdata;
                REG_STEP_TIME:  step_time_reg   <= pwdata;
                REG_TIME_CONST: time_const_reg  <= pwdata;
                default:        ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_sel)
            REG_OCV_BASE:   prdata = ocv_base_reg;
            REG_OCV_SLOPE:  prdata = ocv_slope_reg;
            REG_RESISTANCE: prdata = resistance_reg;
            REG_CAPACITY:   prdata = capacity_reg;
            REG_INIT_CHG:   prdata = init_charge_reg;
            REG_CHG_RATE:   prdata = charge_rate_reg;
            REG_STEP_TIME:  prdata = step_time_reg;
            REG_TIME_CONST: prdata = time_const_reg;
            default:        prdata = '0;
        endcase
    end

    // Filter update: move toward the raw current by k*|raw - smooth|
    assign raw_ge   = (raw_reg >= filt_reg);
    assign diff     = raw_ge ? (raw_reg - filt_reg) : (filt_reg - raw_reg);
    assign prod_q   = mul_p[PROD_W-1:FRAC_BITS];
    assign filt_sum = (SHIFT_W+1)'(filt_reg) + (SHIFT_W+1)'(prod_q);

    always_comb
    begin
        if (raw_ge)
            filt_upd = (|filt_sum[SHIFT_W:DATA_W]) ? MAX_Q : filt_sum[DATA_W-1:0];
        else if (prod_q >= SHIFT_W'(filt_reg))
            filt_upd = '0;
        else
            filt_upd = filt_reg - prod_q[DATA_W-1:0];
    end

    // Charge update, clamped at both ends
    assign chg_sum = (DIV_W+1)'(charge_reg) + (DIV_W+1)'(div_quo);

    always_comb
    begin
        if (chg_reg)
            charge_upd = (|chg_sum[DIV_W:DATA_W]) ? MAX_Q : chg_sum[DATA_W-1:0];
        else if (div_quo >= DIV_W'(charge_reg))
            charge_upd = '0;
        else
            charge_upd = charge_reg - div_quo[DATA_W-1:0];
    end

    // Open-circuit term and terminal voltage clamp
    assign ratio_le  = (ratio_reg <= ONE_Q);
    assign ratio_dev = ratio_le ? (ONE_Q - ratio_reg) : (ratio_reg - ONE_Q);
    assign base_ext  = TOT_W'(ocv_base_reg);
    assign mag_ext   = TOT_W'(prod_q);

    always_comb
    begin
        if (total_reg > TV_MAX)
            tv_sat = TV_POS;
        else if (total_reg < TV_MIN)
            tv_sat = TV_NEG;
        else
            tv_sat = total_reg[DATA_W-1:0];
    end

    assign special = act_reg || low_reg;

    // Sequencer next state
    always_comb
    begin
        state_next   = state_reg;
        act_next     = act_reg;
        low_next     = low_reg;
        chg_next     = chg_reg;
        volt_next    = volt_reg;
        power_next   = power_reg;
        raw_next     = raw_reg;
        k_next       = k_reg;
        ratio_next   = ratio_reg;
        total_next   = total_reg;
        filt_next    = filt_reg;
        charge_next  = charge_reg;
        rv_next      = rv_reg;
        tv_next      = tv_reg;
        cl_next      = cl_reg;
        lc_next      = lc_reg;
        sc_next      = sc_reg;
        vtl_next     = vtl_reg;
        div_start    = 1'b0;
        div_dividend = '0;
        div_divisor  = '0;
        mul_a        = '0;
        mul_b        = '0;

        // Result taken downstream
        if (rv_reg && !result_stall)
            rv_next = 1'b0;

        case (state_reg)
            S_IDLE:
            begin
                if (item_valid)
                begin
                    act_next   = action;
                    chg_next   = charging;
                    volt_next  = bus_voltage;
                    power_next = load_power;
                    low_next   = 1'b0;
                    if (action)
                    begin
                        filt_next   = '0;
                        charge_next = init_charge_reg;
                        state_next  = S_OUT;
                    end
                    else if (bus_voltage < MV_THRESH)
                    begin
                        low_next   = 1'b1;
                        state_next = S_OUT;
                    end
                    else
                    begin
                        state_next = S_RAW_GO;
                    end
                end
            end
            S_RAW_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({power_reg, {FRAC_BITS{1'b0}}});
                div_divisor  = volt_reg;
                state_next   = S_RAW_WAIT;
            end
            S_RAW_WAIT:
            begin
                if (div_stat.done)
                begin
                    raw_next   = sat_quo(div_quo);
                    state_next = S_K_GO;
                end
            end
            S_K_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({step_time_reg, {FRAC_BITS{1'b0}}});
                div_divisor  = time_const_reg;
                state_next   = S_K_WAIT;
            end
            S_K_WAIT:
            begin
                if (div_stat.done)
                begin
                    k_next     = sat_quo(div_quo);
                    state_next = S_FILT_MUL;
                end
            end
            S_FILT_MUL:
            begin
                mul_a      = diff;
                mul_b      = k_reg;
                state_next = S_FILT_UPD;
            end
            S_FILT_UPD:
            begin
                filt_next  = filt_upd;
                state_next = S_AMT_MUL;
            end
            S_AMT_MUL:
            begin
                mul_a      = step_time_reg;
                mul_b      = chg_reg ? charge_rate_reg : filt_reg;
                state_next = S_AMT_GO;
            end
            S_AMT_GO:
            begin
                // step*current in seconds to amp-hours
                div_start    = 1'b1;
                div_dividend = DIV_W'(prod_q);
                div_divisor  = SEC_PER_HOUR;
                state_next   = S_AMT_WAIT;
            end
            S_AMT_WAIT:
            begin
                if (div_stat.done)
                begin
                    charge_next = charge_upd;
                    state_next  = S_RATIO_GO;
                end
            end
            S_RATIO_GO:
            begin
                div_start    = 1'b1;
                div_dividend = DIV_W'({charge_reg, {FRAC_BITS{1'b0}}});
                div_divisor  = capacity_reg;
                state_next   = S_RATIO_WAIT;
            end
            S_RATIO_WAIT:
            begin
                if (div_stat.done)
                begin
                    ratio_next = sat_quo(div_quo);
                    state_next = S_OCV_MUL;
                end
            end
            S_OCV_MUL:
            begin
                mul_a      = ocv_slope_reg;
                mul_b      = ratio_dev;
                state_next = S_OCV_ACC;
            end
            S_OCV_ACC:
            begin
                total_next = ratio_le ? (base_ext + mag_ext) : (base_ext - mag_ext);
                state_next = S_RES_MUL;
            end
            S_RES_MUL:
            begin
                mul_a      = resistance_reg;
                mul_b      = filt_reg;
                state_next = S_RES_ACC;
            end
            S_RES_ACC:
            begin
                total_next = total_reg - mag_ext;
                state_next = S_OUT;
            end
            S_OUT:
            begin
                if (!rv_reg || !result_stall)
                begin
                    rv_next    = 1'b1;
                    tv_next    = special ? '0 : tv_sat;
                    cl_next    = low_reg ? '0 : charge_reg;
                    lc_next    = special ? '0 : raw_reg;
                    sc_next    = special ? '0 : filt_reg;
                    vtl_next   = low_reg;
                    state_next = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    // Sequencer state, model state and result register
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg  <= S_IDLE;
            act_reg    <= 1'b0;
            low_reg    <= 1'b0;
            chg_reg    <= 1'b0;
            volt_reg   <= '0;
            power_reg  <= '0;
            raw_reg    <= '0;
            k_reg      <= '0;
            ratio_reg  <= '0;
            total_reg  <= '0;
            filt_reg   <= '0;
            charge_reg <= '0;
            rv_reg     <= 1'b0;
            tv_reg     <= '0;
            cl_reg     <= '0;
            lc_reg     <= '0;
            sc_reg     <= '0;
            vtl_reg    <= 1'b0;
        end
        else
        begin
            state_reg  <= state_next;
            act_reg    <= act_next;
            low_reg    <= low_next;
            chg_reg    <= chg_next;
            volt_reg   <= volt_next;
            power_reg  <= power_next;
            raw_reg    <= raw_next;
            k_reg      <= k_next;
            ratio_reg  <= ratio_next;
            total_reg  <= total_next;
            filt_reg   <= filt_next;
            charge_reg <= charge_next;
            rv_reg     <= rv_next;
            tv_reg     <= tv_next;
            cl_reg     <= cl_next;
            lc_reg     <= lc_next;
            sc_reg     <= sc_next;
            vtl_reg    <= vtl_next;
        end
    end

    assign item_stall       = (state_reg != S_IDLE);
    assign result_valid     = rv_reg;
    assign terminal_voltage = tv_reg;
    assign charge_left      = cl_reg;
    assign load_current     = lc_reg;
    assign smooth_current   = sc_reg;
    assign voltage_too_low  = vtl_reg;

    // Divider finishes only while the sequencer waits for it
    ap_done_in_wait: assert property (@(posedge clk) disable iff (!rst_n)
        div_stat.done |-> (state_reg == S_RAW_WAIT || state_reg == S_K_WAIT ||
                           state_reg == S_AMT_WAIT || state_reg == S_RATIO_WAIT))
        else $error("divider result arrived outside a wait state");

    // One word at a time: an accepted word closes the input side
    ap_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
        (item_valid && !item_stall) |=> item_stall)
        else $error("input not stalled after accepting a word");

    // Low-voltage results carry nothing but the flag
    ap_low_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (result_valid && voltage_too_low) |->
            (terminal_voltage == '0 && charge_left == '0 &&
             load_current == '0 && smooth_current == '0))
        else $error("low-voltage result has nonzero fields");

endmodule
